FILE: sv/fill_row_gaps_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the row gap filler
// Clocked property wrappers shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef FILL_ROW_GAPS_TOP_ASSERT_SVH
`define FILL_ROW_GAPS_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FRG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define FRG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/frg_pkg.sv
// ----------------------------------------------------------------------------
// Row gap filler package
// Shared constants and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package frg_pkg;

  // Width of the max_gap register and of the fill counter.
  localparam int GAP_BITS = 6;

  // Value of max_gap after reset.
  localparam logic [GAP_BITS-1:0] MAX_GAP_RESET = 6'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted input transaction
    logic eval;       // evaluate the gap and update the previous pair
    logic load_fill;  // load one gap row into the output register
    logic load_pass;  // load the current pair into the output register
  } frg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_ok;    // the current pair opens a gap that is filled
    logic last_fill;  // one gap row remains
    logic slot_free;  // the output register can take a result this cycle
  } frg_status_t;

endpackage

FILE: sv/frg_in_if.sv
// ----------------------------------------------------------------------------
// Input channel of the row gap filler
// Valid/ready channel carrying one (row, heat, first) entry.
// ----------------------------------------------------------------------------
interface frg_in_if #(
  parameter int ROW_BITS  = 32,
  parameter int HEAT_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [ROW_BITS-1:0]  row;
  logic signed [HEAT_BITS-1:0] heat;
  logic                        first;

  modport source (output valid, row, heat, first, input ready);
  modport sink   (input valid, row, heat, first, output ready);
endinterface

FILE: sv/frg_out_if.sv
// ----------------------------------------------------------------------------
// Output channel of the row gap filler
// Valid/ready channel carrying one emitted entry.
// ----------------------------------------------------------------------------
interface frg_out_if #(
  parameter int ROW_BITS  = 32,
  parameter int HEAT_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [ROW_BITS-1:0]  out_row;
  logic signed [HEAT_BITS-1:0] out_heat;
  logic                        filled;
  logic                        last;

  modport source (output valid, out_row, out_heat, filled, last, input ready);
  modport sink   (input valid, out_row, out_heat, filled, last, output ready);
endinterface

FILE: sv/fill_row_gaps_top.sv
// ----------------------------------------------------------------------------
// Row gap filler, top level
// Fills short runs of missing rows between same-side entries of a sorted list.
// ----------------------------------------------------------------------------
// Usage:
//   items carries one (row, heat, first) entry per transaction; first marks
//   the start of a new list and makes the block forget the previous entry.
//   results carries (out_row, out_heat, filled, last) transactions. When the
//   previous and current heats share a nonzero sign and between 1 and
//   min(max_gap, MAX_FILL) rows are missing, every missing row is emitted in
//   ascending order with the heat of smaller magnitude, filled set. The
//   current entry then always follows with filled clear and last set.
//   The user writes max_gap (cfg_we, cfg_wdata) only while idle; not enforced.
// Timing:
//   An entry is captured, then evaluated in the next cycle; without a fill
//   its result is loaded in that evaluation cycle if the output slot is free.
//   A gap yields one result per cycle from the single output register
//   unless the receiver stalls. One entry is in flight at a time.
// Reset and stalls:
//   Reset empties the output register, forgets the previous entry and sets
//   max_gap to 4. A stalled receiver holds the output register; the next
//   entry is still taken and evaluated, and the controller waits only when
//   it has a new result to load.
// ----------------------------------------------------------------------------
module fill_row_gaps_top #(
  parameter int ROW_BITS  = 32,
  parameter int HEAT_BITS = 32,
  parameter int MAX_FILL  = 63
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [frg_pkg::GAP_BITS-1:0] cfg_wdata,
  frg_in_if.sink                       items,
  frg_out_if.source                    results
);

  frg_pkg::frg_cmd_t    cmd;
  frg_pkg::frg_status_t status;

  // The controller decides when each transaction is taken and when the
  // output register is loaded; the datapath holds every value.
  frg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  frg_dp #(
    .ROW_BITS  (ROW_BITS),
    .HEAT_BITS (HEAT_BITS),
    .MAX_FILL  (MAX_FILL)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_row    (items.row),
    .in_heat   (items.heat),
    .in_first  (items.first),
    .cmd       (cmd),
    .status    (status),
    .res       (results)
  );

endmodule

FILE: sv/frg_ctrl.sv
// ----------------------------------------------------------------------------
// Row gap filler controller
// Sequences capture, evaluation, gap rows and the pass-through result.
// ----------------------------------------------------------------------------
`include "fill_row_gaps_top_assert.svh"

module frg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  frg_pkg::frg_status_t status,
  output frg_pkg::frg_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_FILL,
    S_PASS
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.fill_ok) begin
          state_next = S_FILL;
        end else if (status.slot_free) begin
          // No gap to fill: the pair goes straight out.
          cmd.load_pass = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_PASS;
        end
      end
      S_FILL: begin
        if (status.slot_free) begin
          cmd.load_fill = 1'b1;
          if (status.last_fill) begin
            state_next = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (status.slot_free) begin
          cmd.load_pass = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `FRG_ASSERT(a_single_load, clk, rst, !(cmd.load_fill && cmd.load_pass), "two loads at once")
  `FRG_ASSERT_NEXT(a_fill_ends_in_pass, clk, rst, cmd.load_fill && status.last_fill, state == S_PASS, "final gap row not followed by the pass-through")

endmodule

FILE: sv/frg_dp.sv
// ----------------------------------------------------------------------------
// Row gap filler datapath
// Holds the previous pair, the gap evaluation, the fill counter and the
// output register.
// ----------------------------------------------------------------------------
`include "fill_row_gaps_top_assert.svh"

module frg_dp #(
  parameter int ROW_BITS  = 32,
  parameter int HEAT_BITS = 32,
  parameter int MAX_FILL  = 63
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [frg_pkg::GAP_BITS-1:0]        cfg_wdata,
  input  logic signed [ROW_BITS-1:0]          in_row,
  input  logic signed [HEAT_BITS-1:0]         in_heat,
  input  logic                                in_first,
  input  frg_pkg::frg_cmd_t                   cmd,
  output frg_pkg::frg_status_t                status,
  frg_out_if.source                           res
);

  localparam int GB = frg_pkg::GAP_BITS;

  logic [GB-1:0]               max_gap;
  logic signed [ROW_BITS-1:0]  cur_row;
  logic signed [HEAT_BITS-1:0] cur_heat;
  logic                        cur_first;
  logic signed [ROW_BITS-1:0]  prev_row;
  logic signed [HEAT_BITS-1:0] prev_heat;
  logic                        have_prev;
  logic signed [ROW_BITS-1:0]  fill_row;
  logic signed [HEAT_BITS-1:0] fill_heat;
  logic [GB-1:0]               remaining;
  logic                        out_valid;

  logic [GB-1:0]               limit;
  logic [ROW_BITS:0]           lim_ext;
  logic [ROW_BITS:0]           diff;
  logic [ROW_BITS:0]           diff_m1;
  logic                        same_side;
  logic signed [HEAT_BITS-1:0] fill_val;

  // Fill limit is the smaller of the register and the build-time capacity.
  assign limit   = (max_gap < GB'(MAX_FILL)) ? max_gap : GB'(MAX_FILL);
  assign lim_ext = (ROW_BITS+1)'({1'b0, limit} + (GB+1)'(1));

  // Row difference with one extra bit so that it never wraps.
  assign diff    = {cur_row[ROW_BITS-1], cur_row} - {prev_row[ROW_BITS-1], prev_row};
  assign diff_m1 = diff - (ROW_BITS+1)'(1);

  assign same_side = (prev_heat[HEAT_BITS-1] == cur_heat[HEAT_BITS-1])
                     && (prev_heat != '0) && (cur_heat != '0);

  // Heat of smaller magnitude on the common side.
  always_comb begin
    if (!prev_heat[HEAT_BITS-1]) begin
      fill_val = (prev_heat < cur_heat) ? prev_heat : cur_heat;
    end else begin
      fill_val = (prev_heat > cur_heat) ? prev_heat : cur_heat;
    end
  end

  assign status.fill_ok   = have_prev && !cur_first && same_side && !diff[ROW_BITS]
                            && (diff >= (ROW_BITS+1)'(2)) && (diff <= lim_ext);
  assign status.last_fill = (remaining == GB'(1));
  assign status.slot_free = !out_valid || res.ready;

  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap   <= frg_pkg::MAX_GAP_RESET;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_gap <= cfg_wdata;
      end
      if (cmd.eval) begin
        have_prev <= 1'b1;
      end
      if (cmd.load_fill || cmd.load_pass) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_row   <= in_row;
      cur_heat  <= in_heat;
      cur_first <= in_first;
    end
    if (cmd.eval) begin
      prev_row  <= cur_row;
      prev_heat <= cur_heat;
      fill_row  <= prev_row + ROW_BITS'(1);
      fill_heat <= fill_val;
      remaining <= diff_m1[GB-1:0];
    end
    if (cmd.load_fill) begin
      res.out_row  <= fill_row;
      res.out_heat <= fill_heat;
      res.filled   <= 1'b1;
      res.last     <= 1'b0;
      fill_row     <= fill_row + ROW_BITS'(1);
      remaining    <= remaining - GB'(1);
    end else if (cmd.load_pass) begin
      res.out_row  <= cur_row;
      res.out_heat <= cur_heat;
      res.filled   <= 1'b0;
      res.last     <= 1'b1;
    end
  end

  `FRG_ASSERT_NEXT(a_fill_result, clk, rst, cmd.load_fill, res.valid && res.filled && !res.last, "gap row loaded with wrong flags")
  `FRG_ASSERT_NEXT(a_pass_result, clk, rst, cmd.load_pass, res.valid && res.last && !res.filled && res.out_row == $past(cur_row), "pass-through loaded wrongly")

endmodule
